// ----- hdl/crp_pkg.sv -----
package crp_pkg;

    // total register stages from input transfer to output register
    localparam int unsigned LAT = 70;

    localparam logic [8:0] REST_RESET = 9'd205;

    // input item, first field in the lowest bits
    typedef struct packed {
        logic [15:0] second_mass;
        logic [15:0] second_radius;
        logic [15:0] second_vy;
        logic [15:0] second_vx;
        logic [20:0] second_y;
        logic [20:0] second_x;
        logic [15:0] first_mass;
        logic [15:0] first_radius;
        logic [15:0] first_vy;
        logic [15:0] first_vx;
        logic [20:0] first_y;
        logic [20:0] first_x;
    } in_item_t;

    // result item without the hit flag, also used for the pass-through line
    typedef struct packed {
        logic [15:0] second_vy;
        logic [15:0] second_vx;
        logic [20:0] second_y;
        logic [20:0] second_x;
        logic [15:0] first_vy;
        logic [15:0] first_vx;
        logic [20:0] first_y;
        logic [20:0] first_x;
    } out_item_t;

    function automatic logic [15:0] add_sat16(logic [15:0] v, logic [17:0] mag, logic neg);
        logic [19:0] ext;
        logic [19:0] sum;
        logic [15:0] res;
        ext = neg ? (~{2'b00, mag} + 20'd1) : {2'b00, mag};
        sum = {{4{v[15]}}, v} + ext;
        if (!sum[19] && (|sum[18:15]))
            res = 16'h7FFF;
        else if (sum[19] && !(&sum[18:15]))
            res = 16'h8000;
        else
            res = sum[15:0];
        return res;
    endfunction

    function automatic logic [20:0] add_sat21(logic [20:0] v, logic [16:0] mag, logic neg);
        logic [22:0] ext;
        logic [22:0] sum;
        logic [20:0] res;
        ext = neg ? (~{6'b0, mag} + 23'd1) : {6'b0, mag};
        sum = {{2{v[20]}}, v} + ext;
        if (!sum[22] && (|sum[21:20]))
            res = 21'h0FFFFF;
        else if (sum[22] && !(&sum[21:20]))
            res = 21'h100000;
        else
            res = sum[20:0];
        return res;
    endfunction

endpackage

// ----- hdl/circle_pair_collision_response_unit.sv -----
// Circle pair collision response.
// s_axis carries one circle pair per transfer; m_axis returns the resolved pair,
// with tuser set when an approaching contact was resolved (impulse plus overlap
// split), else all values pass through unchanged.
// cfg_valid/cfg_data write the restitution register (1/256 units); cfg_ready is
// always high. Write it only while the pipeline is empty.
// Throughput: one pair per cycle while the receiver does not stall. The pipeline
// depth is set by the chain of pipelined units: a 17-stage square root feeding
// a 17-stage divider on the position path, and on the velocity path a 44-stage
// divider by the mass sum followed by an 18-stage divider by the squared
// distance.
// When the receiver stalls with a result waiting, the whole pipeline freezes and
// s_axis_tready drops in the same cycle; nothing is lost or repeated, and bubbles
// keep their place.
// Reset clears all valid bits and sets restitution to 205 (about 0.8).
module circle_pair_collision_response_unit
    import crp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // first_x, first_y, first_vx, first_vy, first_radius, first_mass,
    // second_x, second_y, second_vx, second_vy, second_radius, second_mass
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // new_first_x, new_first_y, new_first_vx, new_first_vy,
    // new_second_x, new_second_y, new_second_vx, new_second_vy
    output logic [151:0] m_axis_tdata,
    // hit
    output logic [0:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [8:0]   cfg_data
);

    logic            en;
    logic [LAT-1:0]  vld_reg;
    logic [8:0]      rest_reg;
    in_item_t        in_w;
    out_item_t       pass_w;
    out_item_t       pass69;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;
    assign in_w          = in_item_t'(s_axis_tdata[211:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rest_reg <= REST_RESET;
        else if (cfg_valid)
            rest_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    assign pass_w.first_x   = in_w.first_x;
    assign pass_w.first_y   = in_w.first_y;
    assign pass_w.first_vx  = in_w.first_vx;
    assign pass_w.first_vy  = in_w.first_vy;
    assign pass_w.second_x  = in_w.second_x;
    assign pass_w.second_y  = in_w.second_y;
    assign pass_w.second_vx = in_w.second_vx;
    assign pass_w.second_vy = in_w.second_vy;

    crp_delay #(.W($bits(out_item_t)), .DEPTH(69)) u_pass (
        .clk(clk), .en(en), .din(pass_w), .dout(pass69)
    );

    // ---- stage 1: offsets
    logic [21:0] p1_dx_reg, p1_dy_reg;
    logic [16:0] p1_dvx_reg, p1_dvy_reg, p1_rs_reg;
    logic [15:0] p1_m1_reg, p1_m2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_dx_reg  <= {in_w.first_x[20], in_w.first_x} - {in_w.second_x[20], in_w.second_x};
            p1_dy_reg  <= {in_w.first_y[20], in_w.first_y} - {in_w.second_y[20], in_w.second_y};
            p1_dvx_reg <= {in_w.first_vx[15], in_w.first_vx}
                          - {in_w.second_vx[15], in_w.second_vx};
            p1_dvy_reg <= {in_w.first_vy[15], in_w.first_vy}
                          - {in_w.second_vy[15], in_w.second_vy};
            p1_rs_reg  <= {1'b0, in_w.first_radius} + {1'b0, in_w.second_radius};
            p1_m1_reg  <= (in_w.first_mass == 16'd0) ? 16'd1 : in_w.first_mass;
            p1_m2_reg  <= (in_w.second_mass == 16'd0) ? 16'd1 : in_w.second_mass;
        end
    end

    // ---- stage 2: squares and dot terms
    logic signed [43:0] dx2_w, dy2_w;
    logic        [33:0] rs2_w;
    logic signed [34:0] pdx_w, pdy_w;
    logic        [21:0] adx_w, ady_w;

    assign dx2_w = $signed(p1_dx_reg) * $signed(p1_dx_reg);
    assign dy2_w = $signed(p1_dy_reg) * $signed(p1_dy_reg);
    assign rs2_w = p1_rs_reg * p1_rs_reg;
    assign pdx_w = $signed(p1_dvx_reg) * $signed(p1_dx_reg[17:0]);
    assign pdy_w = $signed(p1_dvy_reg) * $signed(p1_dy_reg[17:0]);
    assign adx_w = p1_dx_reg[21] ? (~p1_dx_reg + 22'd1) : p1_dx_reg;
    assign ady_w = p1_dy_reg[21] ? (~p1_dy_reg + 22'd1) : p1_dy_reg;

    logic [43:0] p2_dx2_reg, p2_dy2_reg;
    logic [33:0] p2_rs2_reg;
    logic [34:0] p2_pdx_reg, p2_pdy_reg;
    logic [35:0] p2_grp_reg;
    logic [15:0] p2_m1_reg, p2_m2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_dx2_reg <= dx2_w;
            p2_dy2_reg <= dy2_w;
            p2_rs2_reg <= rs2_w;
            p2_pdx_reg <= pdx_w;
            p2_pdy_reg <= pdy_w;
            // signs of dx, dy and their magnitudes
            p2_grp_reg <= {p1_dx_reg[21], p1_dy_reg[21], adx_w[16:0], ady_w[16:0]};
            p2_m1_reg  <= p1_m1_reg;
            p2_m2_reg  <= p1_m2_reg;
        end
    end

    // ---- stage 3: distance, contact test, dot product
    logic [44:0] d2_full_w;
    logic [35:0] dot_w;

    assign d2_full_w = {1'b0, p2_dx2_reg} + {1'b0, p2_dy2_reg};
    assign dot_w     = {p2_pdx_reg[34], p2_pdx_reg} + {p2_pdy_reg[34], p2_pdy_reg};

    logic [33:0] p3_d2_reg;
    logic        p3_contact_reg;
    logic [35:0] p3_dot_reg;
    logic [15:0] p3_m1_reg, p3_m2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_d2_reg      <= d2_full_w[33:0];
            p3_contact_reg <= (d2_full_w != 45'd0) && (d2_full_w <= {11'b0, p2_rs2_reg});
            p3_dot_reg     <= dot_w;
            p3_m1_reg      <= p2_m1_reg;
            p3_m2_reg      <= p2_m2_reg;
        end
    end

    // ---- stage 4: approach test, |dot| * (256 + e)
    logic [35:0] dot_abs_w;
    logic [9:0]  k_w;
    logic [44:0] dk_w;

    assign dot_abs_w = p3_dot_reg[35] ? (~p3_dot_reg + 36'd1) : p3_dot_reg;
    assign k_w       = 10'd256 + {1'b0, rest_reg};
    assign dk_w      = dot_abs_w[34:0] * k_w;

    logic        p4_hit_reg;
    logic [43:0] p4_dk_reg;
    logic [16:0] p4_msum_reg;
    logic [15:0] p4_m1_reg, p4_m2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_hit_reg  <= p3_contact_reg && (p3_dot_reg[35] || (p3_dot_reg == 36'd0));
            p4_dk_reg   <= dk_w[43:0];
            p4_msum_reg <= {1'b0, p3_m1_reg} + {1'b0, p3_m2_reg};
            p4_m1_reg   <= p3_m1_reg;
            p4_m2_reg   <= p3_m2_reg;
        end
    end

    // ---- stage 5: impulse numerators, rounding half added
    logic [59:0] pr1_w, pr2_w;

    assign pr1_w = p4_dk_reg * p4_m2_reg;
    assign pr2_w = p4_dk_reg * p4_m1_reg;

    logic [59:0] p5_n1_reg, p5_n2_reg;
    logic [16:0] p5_msum_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_n1_reg   <= pr1_w + {44'b0, p4_msum_reg[16:1]};
            p5_n2_reg   <= pr2_w + {44'b0, p4_msum_reg[16:1]};
            p5_msum_reg <= p4_msum_reg;
        end
    end

    // impulse magnitudes, ready at stage 49
    logic [43:0] q1_w, q2_w;

    crp_div #(.NW(60), .DW(17), .QW(44)) u_div_s1 (
        .clk(clk), .en(en), .n(p5_n1_reg), .d(p5_msum_reg), .q(q1_w)
    );
    crp_div #(.NW(60), .DW(17), .QW(44)) u_div_s2 (
        .clk(clk), .en(en), .n(p5_n2_reg), .d(p5_msum_reg), .q(q2_w)
    );

    // ---- position path: sqrt from stage 3 to stage 20
    logic [16:0] root_w;
    logic [16:0] rs20_w;
    logic [35:0] grp20_w;

    crp_sqrt #(.VW(34)) u_sqrt (
        .clk(clk), .en(en), .v(p3_d2_reg), .root(root_w)
    );
    crp_delay #(.W(17), .DEPTH(19)) u_dly_rs (
        .clk(clk), .en(en), .din(p1_rs_reg), .dout(rs20_w)
    );
    crp_delay #(.W(36), .DEPTH(18)) u_dly_grp20 (
        .clk(clk), .en(en), .din(p2_grp_reg), .dout(grp20_w)
    );

    logic [16:0] ov_w;
    logic [33:0] ovx_w, ovy_w;

    assign ov_w  = rs20_w - root_w;
    assign ovx_w = ov_w * grp20_w[33:17];
    assign ovy_w = ov_w * grp20_w[16:0];

    logic [34:0] p21_ncx_reg, p21_ncy_reg;
    logic [17:0] p21_dc_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p21_ncx_reg <= {1'b0, ovx_w} + {18'b0, root_w};
            p21_ncy_reg <= {1'b0, ovy_w} + {18'b0, root_w};
            p21_dc_reg  <= {root_w, 1'b0};
        end
    end

    logic [16:0] cxm_w, cym_w, cxm69_w, cym69_w;

    crp_div #(.NW(35), .DW(18), .QW(17)) u_div_cx (
        .clk(clk), .en(en), .n(p21_ncx_reg), .d(p21_dc_reg), .q(cxm_w)
    );
    crp_div #(.NW(35), .DW(18), .QW(17)) u_div_cy (
        .clk(clk), .en(en), .n(p21_ncy_reg), .d(p21_dc_reg), .q(cym_w)
    );
    crp_delay #(.W(34), .DEPTH(31)) u_dly_c (
        .clk(clk), .en(en), .din({cxm_w, cym_w}), .dout({cxm69_w, cym69_w})
    );

    // ---- velocity path: stages 49 to 69
    logic [33:0] d2_49_w;
    logic [35:0] grp49_w;
    logic [1:0]  sgn69_w;
    logic        hit69_w;

    crp_delay #(.W(34), .DEPTH(46)) u_dly_d2 (
        .clk(clk), .en(en), .din(p3_d2_reg), .dout(d2_49_w)
    );
    crp_delay #(.W(36), .DEPTH(29)) u_dly_grp49 (
        .clk(clk), .en(en), .din(grp20_w), .dout(grp49_w)
    );
    crp_delay #(.W(2), .DEPTH(20)) u_dly_sgn (
        .clk(clk), .en(en), .din(grp49_w[35:34]), .dout(sgn69_w)
    );
    crp_delay #(.W(1), .DEPTH(65)) u_dly_hit (
        .clk(clk), .en(en), .din(p4_hit_reg), .dout(hit69_w)
    );

    logic [60:0] pv_w [4];

    assign pv_w[0] = q1_w * grp49_w[33:17];
    assign pv_w[1] = q1_w * grp49_w[16:0];
    assign pv_w[2] = q2_w * grp49_w[33:17];
    assign pv_w[3] = q2_w * grp49_w[16:0];

    logic [61:0] p50_n_reg [4];
    logic [41:0] p50_den_reg;
    logic [61:0] p51_n_reg [4];
    logic [41:0] p51_den_reg;
    logic [3:0]  p51_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                p50_n_reg[i] <= {1'b0, pv_w[i]} + {21'b0, d2_49_w, 7'b0};
                p51_n_reg[i] <= p50_n_reg[i];
                // quotient too large to matter: the velocity saturates anyway
                p51_ovf_reg[i] <= p50_n_reg[i] >= {2'b0, p50_den_reg, 18'b0};
            end
            p50_den_reg <= {d2_49_w, 8'b0};
            p51_den_reg <= p50_den_reg;
        end
    end

    logic [17:0] qv_w [4];
    logic [3:0]  ovf69_w;

    for (genvar j = 0; j < 4; j++)
    begin : g_vdiv
        crp_div #(.NW(62), .DW(42), .QW(18)) u_div_v (
            .clk(clk), .en(en), .n(p51_n_reg[j]), .d(p51_den_reg), .q(qv_w[j])
        );
    end

    crp_delay #(.W(4), .DEPTH(18)) u_dly_ovf (
        .clk(clk), .en(en), .din(p51_ovf_reg), .dout(ovf69_w)
    );

    // ---- stage 70: apply, saturate, output register
    logic [17:0] qf_w [4];
    out_item_t   out_next;
    out_item_t   out_reg;
    logic        hit_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            qf_w[i] = ovf69_w[i] ? {18{1'b1}} : qv_w[i];
        end
        out_next = pass69;
        if (hit69_w)
        begin
            out_next.first_vx  = add_sat16(pass69.first_vx, qf_w[0], sgn69_w[1]);
            out_next.first_vy  = add_sat16(pass69.first_vy, qf_w[1], sgn69_w[0]);
            out_next.second_vx = add_sat16(pass69.second_vx, qf_w[2], !sgn69_w[1]);
            out_next.second_vy = add_sat16(pass69.second_vy, qf_w[3], !sgn69_w[0]);
            out_next.first_x   = add_sat21(pass69.first_x, cxm69_w, sgn69_w[1]);
            out_next.first_y   = add_sat21(pass69.first_y, cym69_w, sgn69_w[0]);
            out_next.second_x  = add_sat21(pass69.second_x, cxm69_w, !sgn69_w[1]);
            out_next.second_y  = add_sat21(pass69.second_y, cym69_w, !sgn69_w[0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
            hit_reg <= hit69_w;
        end
    end

    assign m_axis_tvalid   = vld_reg[LAT-1];
    assign m_axis_tdata    = {4'b0, out_reg};
    assign m_axis_tuser[0] = hit_reg;

    // freeze: no valid bit moves while the output is stalled
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        en && s_axis_tvalid |=> vld_reg[0])
        else $error("accepted transfer not tracked in stage one");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[LAT-2] |=> m_axis_tvalid)
        else $error("item lost before the output register");

endmodule

// ----- hdl/crp_delay.sv -----
module crp_delay #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ----- hdl/crp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Expects n / d < 2^QW; the quotient is floor(n / d).
module crp_div #(
    parameter int unsigned NW = 35,
    parameter int unsigned DW = 18,
    parameter int unsigned QW = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] n,
    input  logic [DW-1:0] d,
    output logic [QW-1:0] q
);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] w_reg   [QW];
    logic [DW-1:0] d_reg   [QW];

    logic [DW-1:0] rem_in [QW];
    logic [QW-1:0] w_in   [QW];
    logic [DW-1:0] d_in   [QW];

    assign rem_in[0] = DW'(n >> QW);
    assign w_in[0]   = n[QW-1:0];
    assign d_in[0]   = d;

    for (genvar i = 0; i < QW; i++)
    begin : g_step
        logic [DW:0]   trial;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] w_next;

        if (i > 0)
        begin : g_link
            assign rem_in[i] = rem_reg[i-1];
            assign w_in[i]   = w_reg[i-1];
            assign d_in[i]   = d_reg[i-1];
        end

        // shift in the next numerator bit, the quotient bit shifts in below
        assign trial    = {rem_in[i], w_in[i][QW-1]};
        assign ge       = trial >= {1'b0, d_in[i]};
        assign rem_next = ge ? DW'(trial - {1'b0, d_in[i]}) : trial[DW-1:0];
        assign w_next   = {w_in[i][QW-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                w_reg[i]   <= w_next;
                d_reg[i]   <= d_in[i];
            end
        end
    end

    assign q = w_reg[QW-1];

endmodule

// ----- hdl/crp_sqrt.sv -----
// Pipelined integer square root, one root bit per stage: root = floor(sqrt(v)).
module crp_sqrt #(
    parameter int unsigned VW = 34
) (
    input  logic               clk,
    input  logic               en,
    input  logic [VW-1:0]      v,
    output logic [VW/2-1:0]    root
);

    localparam int unsigned RW = VW / 2;

    logic [RW:0]   rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [VW-1:0] v_reg    [RW];

    logic [RW:0]   rem_in  [RW];
    logic [RW-1:0] root_in [RW];
    logic [VW-1:0] v_in    [RW];

    assign rem_in[0]  = '0;
    assign root_in[0] = '0;
    assign v_in[0]    = v;

    for (genvar i = 0; i < RW; i++)
    begin : g_step
        logic [RW+2:0] acc;
        logic [RW+2:0] trial;
        logic          ge;
        logic [RW:0]   rem_next;
        logic [RW-1:0] root_next;
        logic [VW-1:0] v_next;

        if (i > 0)
        begin : g_link
            assign rem_in[i]  = rem_reg[i-1];
            assign root_in[i] = root_reg[i-1];
            assign v_in[i]    = v_reg[i-1];
        end

        // bring down the next two bits and try root*4+1
        assign acc       = {rem_in[i], v_in[i][VW-1:VW-2]};
        assign trial     = {1'b0, root_in[i], 2'b01};
        assign ge        = acc >= trial;
        assign rem_next  = ge ? (RW+1)'(acc - trial) : acc[RW:0];
        assign root_next = {root_in[i][RW-2:0], ge};
        assign v_next    = {v_in[i][VW-3:0], 2'b00};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                v_reg[i]    <= v_next;
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

// ----- sim/tb.sv -----
module tb;
    import crp_pkg::*;

    typedef struct {
        logic [151:0] data;
        logic         hit;
    } pair_result_t;

    // result saturates to w bits
    function automatic longint sat_to(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // round to nearest, halves away from zero
    function automatic longint div_round(longint n, longint den);
        longint q;
        if (n < 0)
        begin
            q = (-n + den / 2) / den;
            return -q;
        end
        q = (n + den / 2) / den;
        return q;
    endfunction

    function automatic longint floor_sqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic pair_result_t resolve_pair(in_item_t p, logic [8:0] e);
        pair_result_t res;
        out_item_t o;
        longint x1, y1, vx1, vy1, x2, y2, vx2, vy2, m1, m2, r1, r2;
        longint dx, dy, d2, rs, dot, k, msum, s1, s2, den, d, ov, cx, cy;
        x1 = longint'($signed(p.first_x));
        y1 = longint'($signed(p.first_y));
        vx1 = longint'($signed(p.first_vx));
        vy1 = longint'($signed(p.first_vy));
        x2 = longint'($signed(p.second_x));
        y2 = longint'($signed(p.second_y));
        vx2 = longint'($signed(p.second_vx));
        vy2 = longint'($signed(p.second_vy));
        r1 = longint'(p.first_radius);
        r2 = longint'(p.second_radius);
        m1 = (p.first_mass == 0) ? 1 : longint'(p.first_mass);
        m2 = (p.second_mass == 0) ? 1 : longint'(p.second_mass);
        o.first_x = p.first_x;
        o.first_y = p.first_y;
        o.first_vx = p.first_vx;
        o.first_vy = p.first_vy;
        o.second_x = p.second_x;
        o.second_y = p.second_y;
        o.second_vx = p.second_vx;
        o.second_vy = p.second_vy;
        res.hit = 1'b0;
        dx = x1 - x2;
        dy = y1 - y2;
        d2 = dx * dx + dy * dy;
        rs = r1 + r2;
        if (d2 != 0 && d2 <= rs * rs)
        begin
            dot = (vx1 - vx2) * dx + (vy1 - vy2) * dy;
            if (dot <= 0)
            begin
                k = 256 + longint'(e);
                msum = m1 + m2;
                s1 = div_round(dot * k * m2, msum);
                s2 = div_round(dot * k * m1, msum);
                den = 256 * d2;
                d = floor_sqrt(d2);
                ov = rs - d;
                cx = div_round(ov * dx, 2 * d);
                cy = div_round(ov * dy, 2 * d);
                o.first_vx = 16'(sat_to(vx1 - div_round(s1 * dx, den), 16));
                o.first_vy = 16'(sat_to(vy1 - div_round(s1 * dy, den), 16));
                o.second_vx = 16'(sat_to(vx2 + div_round(s2 * dx, den), 16));
                o.second_vy = 16'(sat_to(vy2 + div_round(s2 * dy, den), 16));
                o.first_x = 21'(sat_to(x1 + cx, 21));
                o.first_y = 21'(sat_to(y1 + cy, 21));
                o.second_x = 21'(sat_to(x2 - cx, 21));
                o.second_y = 21'(sat_to(y2 - cy, 21));
                res.hit = 1'b1;
            end
        end
        res.data = {4'b0, o};
        return res;
    endfunction

    class pair_scoreboard;
        pair_result_t pending[$];
        logic [8:0] restitution;
        int errors;

        function void note_pair(in_item_t p);
            pending.push_back(resolve_pair(p, restitution));
        endfunction

        function void check_result(logic [151:0] data, logic hit);
            pair_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result data=%h hit=%b", data, hit);
                return;
            end
            want = pending.pop_front();
            if (want.data !== data || want.hit !== hit)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected data=%h hit=%b, got data=%h hit=%b",
                             want.data, want.hit, data, hit);
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [215:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [8:0]   cfg_data;

    pair_scoreboard board;
    int send_idle_pct;
    int recv_stall_pct;
    longint cycles;

    circle_pair_collision_response_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // sample results at the rising edge
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser[0]);

    // receiver stall pattern, changed on the falling edge
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // valid stays high after a transfer so items can follow back to back
    task automatic send_pair(in_item_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata <= {4'b0, p};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_pair(p);
        @(negedge clk);
    endtask

    task automatic write_restitution(logic [8:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.restitution = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (LAT + 10) @(negedge clk);
    endtask

    function automatic logic [20:0] rand_near(logic [20:0] base, int span);
        return 21'(longint'($signed(base)) + $urandom_range(2 * span) - span);
    endfunction

    // mostly touching pairs with random content, some far apart or fully random
    function automatic in_item_t random_pair();
        in_item_t p;
        logic [223:0] rnd;
        int span;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        p = rnd[211:0];
        if (($urandom_range(3)) == 0) p.first_mass = 16'($urandom_range(65535, 1));
        if ($urandom_range(9) < 8)
        begin
            span = ($urandom_range(3) == 0) ? 65535 : $urandom_range(2000, 1);
            p.first_radius = 16'($urandom_range(span));
            p.second_radius = 16'($urandom_range(span));
            span = p.first_radius + p.second_radius + 1;
            p.second_x = rand_near(p.first_x, span);
            p.second_y = rand_near(p.first_y, span);
            if ($urandom_range(9) == 0) p.second_x = p.first_x;
        end
        if (p.first_mass == 0 && $urandom_range(3) != 0) p.first_mass = 16'd1;
        if (p.second_mass == 0 && $urandom_range(3) != 0) p.second_mass = 16'd1;
        return p;
    endfunction

    task automatic run_phase(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count) send_pair(random_pair());
        drain();
    endtask

    initial
    begin
        in_item_t p;
        clk = 1'b0;
        rst_n = 1'b0;
        cycles = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        board = new();
        board.restitution = REST_RESET;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // head-on contact, separating pair, coincident centres, extremes
        p = '0;
        p.first_mass = 16'h0100;
        p.second_mass = 16'h0100;
        p.first_radius = 16'd2560;
        p.second_radius = 16'd2560;
        p.second_x = 21'd4000;
        p.first_vx = 16'h0200;
        p.second_vx = 16'hFE00;
        send_pair(p);
        p.first_vx = 16'hFE00;
        p.second_vx = 16'h0200;
        send_pair(p);
        p.second_x = 21'd0;
        send_pair(p);
        p.second_y = 21'd1;
        p.first_mass = 16'd0;
        p.second_mass = 16'hFFFF;
        send_pair(p);
        p.first_x = 21'h0FFFFF;
        p.second_x = 21'h0FFFFF - 21'd100;
        p.first_radius = 16'hFFFF;
        p.second_radius = 16'hFFFF;
        p.first_vx = 16'h8000;
        p.second_vx = 16'h7FFF;
        p.first_vy = 16'h8000;
        p.second_vy = 16'h7FFF;
        send_pair(p);
        p.first_x = 21'h100000;
        p.second_x = 21'h100000 + 21'd100;
        p.first_vx = 16'h7FFF;
        p.second_vx = 16'h8000;
        p.first_mass = 16'hFFFF;
        p.second_mass = 16'd0;
        send_pair(p);
        p = '1;
        send_pair(p);
        p = '0;
        send_pair(p);
        drain();

        write_restitution(9'd0);
        run_phase(150, 0, 0);
        write_restitution(9'd256);
        run_phase(150, 79, 0);
        write_restitution(9'h1FF);
        run_phase(150, 0, 79);
        write_restitution(9'd128);
        run_phase(150, 7, 7);
        write_restitution(REST_RESET);
        run_phase(250, 0, 0);
        write_restitution(9'($urandom_range(511)));
        run_phase(200, 40, 40);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
